// ===== design/tphl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphl_pkg
// Shared types and constants of the timed position history lookup.
// ----------------------------------------------------------------------------
package tphl_pkg;
	localparam int Depth = 16;
	localparam int IdxW = $clog2(Depth);
	localparam int NCoord = 9;
	localparam int CoordW = 24;
	localparam int TimeW = 31;
	localparam int PeriodW = 10;
	localparam int FracW = 16;

	localparam logic [1:0] OP_STORE = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_FILL = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_ACK = 2'd0;
	localparam logic [1:0] ST_NOADJ = 2'd1;
	localparam logic [1:0] ST_OLDEST = 2'd2;
	localparam logic [1:0] ST_INTERP = 2'd3;

	localparam logic [PeriodW-1:0] PERIOD_RESET = PeriodW'(50);

	typedef logic signed [CoordW-1:0] coord_t;
	typedef coord_t [NCoord-1:0] cvec_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic [TimeW-1:0] time_t;

	// memory access bundle from controller to store
	typedef struct packed {
		logic wr;
		idx_t waddr;
		time_t wstamp;
		cvec_t wcoord;
		idx_t raddr;
	} mem_req_t;
endpackage

// ===== design/tphl_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphl_store
// Marker memory: stamp plus nine coordinates per entry, registered read.
// Entries that were never written read as zero through valid bits.
// ----------------------------------------------------------------------------
module tphl_store
	import tphl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output time_t    rstamp,
	output cvec_t    rcoord
);
	time_t stamp_mem [Depth];
	cvec_t coord_mem [Depth];
	logic [Depth-1:0] vld_q;
	time_t rs_q;
	cvec_t rc_q;
	logic rv_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			stamp_mem[req.waddr] <= req.wstamp;
			coord_mem[req.waddr] <= req.wcoord;
		end
		rs_q <= stamp_mem[req.raddr];
		rc_q <= coord_mem[req.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q <= 1'b0;
		end else begin
			if (req.wr) vld_q[req.waddr] <= 1'b1;
			rv_q <= vld_q[req.raddr];
		end
	end

	assign rstamp = rv_q ? rs_q : '0;
	assign rcoord = rv_q ? rc_q : '0;
endmodule

// ===== design/tphl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphl_div
// Restoring divider for the Q0.16 fraction, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tphl_div
	import tphl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  time_t            num,
	input  time_t            den,
	output logic             done,
	output logic [FracW-1:0] quo
);
	localparam int CntW = $clog2(FracW + 1);
	logic [TimeW:0] rem_q;
	time_t den_q;
	logic [FracW-1:0] q_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic [TimeW+1:0] sh;
	logic ge;

	assign sh = {rem_q, 1'b0};
	assign ge = sh >= {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CntW'(FracW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) busy_q <= 1'b0;
		end
	end

	// num < den always, so the quotient of num*2^16 fits in 16 bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			q_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (TimeW+1)'(sh - {2'b0, den_q}) : sh[TimeW:0];
			q_q <= {q_q[FracW-2:0], ge};
		end
	end

	assign done = busy_q && cnt_q == CntW'(1);
	assign quo = {q_q[FracW-2:0], ge};
endmodule

// ===== design/tphl_lerp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphl_lerp
// One coordinate interpolation: a + floor((b-a)*frac/2^16), saturated.
// Two register stages: product, then sum.
// ----------------------------------------------------------------------------
module tphl_lerp
	import tphl_pkg::*;
(
	input  logic             clk,
	input  coord_t           a,
	input  coord_t           b,
	input  logic [FracW-1:0] frac,
	output coord_t           res
);
	logic signed [CoordW:0] diff;
	logic signed [CoordW+FracW+1:0] prod_s1;
	coord_t a_s1;
	logic signed [CoordW+1:0] sum;
	coord_t sat;
	coord_t res_s2;

	assign diff = (CoordW+1)'(b) - (CoordW+1)'(a);

	always_ff @(posedge clk) begin
		prod_s1 <= diff * $signed({1'b0, frac});
		a_s1 <= a;
		res_s2 <= sat;
	end

	// arithmetic shift floors toward minus infinity
	assign sum = (CoordW+2)'(a_s1) + (CoordW+2)'(prod_s1 >>> FracW);

	always_comb begin
		if (sum > (CoordW+2)'(2**(CoordW-1) - 1)) sat = {1'b0, {(CoordW-1){1'b1}}};
		else if (sum < -(CoordW+2)'(2**(CoordW-1))) sat = {1'b1, {(CoordW-1){1'b0}}};
		else sat = sum[CoordW-1:0];
	end

	assign res = res_s2;
endmodule

// ===== design/timed_position_history_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_position_history_lookup
// Ring of timestamped markers with store, fill and time query with lerp.
// ----------------------------------------------------------------------------
// channel     dir  handshake                payload
// s_axis      in   s_axis_tvalid/tready     opcode, times, nine coordinates
// m_axis      out  m_axis_tvalid/tready     status, nine coordinates
// cfg         in   cfg_valid/cfg_ready      fill_period_ms
//
// Store: one memory write on accept. Fill: Depth entries, one entry per memory write.
// Query: up to Depth+1 stamp reads for the walk (one stamp per cycle from
// the marker memory), then two entry reads and, for an interpolation, a fraction
// divide (when the stamps differ) and nine lerp passes through one multiplier.
// Reset empties the ring (entries read as zero); no clearing pass.
// A result waits in the output register; the next item is taken once the
// previous one is delivered.
// ----------------------------------------------------------------------------
module timed_position_history_lookup
	import tphl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// opcode[1:0], request_time[32:2], now_time[63:33], origin_x/y/z,
	// box_min_x/y/z, box_max_x/y/z 24 bits each from bit 64, pad to 296
	input  logic [295:0]       s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// status[1:0], pos_x/y/z, lo_x/y/z, hi_x/y/z 24 bits each from bit 2,
	// pad to 224
	output logic [223:0]       m_axis_tdata,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [PeriodW-1:0] cfg_data
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FILL  = 8'b0000_0010,
		S_WALK  = 8'b0000_0100,
		S_RDI   = 8'b0000_1000,
		S_RDJ   = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_LERP  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	localparam int CntW = $clog2(Depth + 4) + 1;

	state_t st_q;
	logic [PeriodW-1:0] period_q;
	idx_t top_q;
	time_t t_q;
	cvec_t c_q, ci_q, cj_q, res_q;
	time_t ti_q, tj_q;
	idx_t i_q, j_q;
	logic [CntW-1:0] cnt_q;
	logic signed [TimeW+1:0] fstamp_q;
	logic [1:0] status_q;
	logic ovalid_q;
	logic [FracW-1:0] frac_q;

	mem_req_t req;
	time_t rstamp;
	cvec_t rcoord;
	logic div_start, div_done;
	logic [FracW-1:0] quo;
	coord_t la, lb, lres;

	logic [1:0] in_op;
	time_t in_req, in_now;
	cvec_t in_c;
	assign in_op = s_axis_tdata[1:0];
	assign in_req = s_axis_tdata[32:2];
	assign in_now = s_axis_tdata[63:33];
	assign in_c = s_axis_tdata[64 +: NCoord*CoordW];

	assign s_axis_tready = st_q == S_IDLE && !ovalid_q;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {{(224-2-NCoord*CoordW){1'b0}}, res_q, status_q};

	tphl_store u_store (.clk, .arst_n, .req, .rstamp, .rcoord);
	tphl_div u_div (.clk, .arst_n, .start(div_start), .num(time_t'(t_q - ti_q)),
		.den(time_t'(tj_q - ti_q)), .done(div_done), .quo);
	tphl_lerp u_lerp (.clk, .a(la), .b(lb), .frac(frac_q), .res(lres));

	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;
	// walk read address: counter k reads top-k
	idx_t walk_addr;
	assign walk_addr = idx_t'(top_q - cnt_q[IdxW-1:0]);

	always_comb begin
		req.wr = 1'b0;
		req.waddr = '0;
		req.wstamp = '0;
		req.wcoord = c_q;
		req.raddr = walk_addr;
		if (acc && in_op == OP_STORE) begin
			req.wr = 1'b1;
			req.waddr = idx_t'(top_q + 1'b1);
			req.wstamp = in_now;
			req.wcoord = in_c;
		end else if (st_q == S_FILL) begin
			req.wr = 1'b1;
			req.waddr = idx_t'(Depth - 1) - cnt_q[IdxW-1:0];
			req.wstamp = fstamp_q < 0 ? '0 : fstamp_q[TimeW-1:0];
		end
		if (st_q == S_RDI) req.raddr = i_q;
		if (st_q == S_RDJ) req.raddr = j_q;
	end

	assign div_start = st_q == S_RDJ && cnt_q == CntW'(2) && tj_q > ti_q;
	// cnt during lerp selects coordinate; lerp output passes its product and sum registers
	assign la = ci_q[cnt_q[3:0] < 4'(NCoord) ? cnt_q[3:0] : 4'd0];
	assign lb = cj_q[cnt_q[3:0] < 4'(NCoord) ? cnt_q[3:0] : 4'd0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			period_q <= PERIOD_RESET;
			top_q <= idx_t'(Depth - 1);
			ovalid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_valid) period_q <= cfg_data;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						cnt_q <= '0;
						case (in_op)
							OP_STORE: begin
								top_q <= idx_t'(top_q + 1'b1);
								ovalid_q <= 1'b1;
							end
							OP_FILL: begin
								top_q <= idx_t'(Depth - 1);
								st_q <= S_FILL;
							end
							OP_QUERY: st_q <= S_WALK;
							default: ovalid_q <= 1'b1;
						endcase
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(Depth - 1)) begin
						st_q <= S_IDLE;
						ovalid_q <= 1'b1;
					end
				end
				S_WALK: begin
					// cnt_q counts reads issued; data for read k-1 arrives now
					if (cnt_q != '0 && (rstamp <= t_q || cnt_q == CntW'(Depth))) begin
						st_q <= S_RDI;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_RDI: st_q <= S_RDJ;
				S_RDJ: begin
					if (cnt_q == CntW'(2)) begin
						st_q <= tj_q > ti_q ? S_DIV : S_LERP;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CntW'(1) && status_q != ST_INTERP) begin
							st_q <= S_OUT;
						end
					end
				end
				S_DIV: if (div_done) st_q <= S_LERP;
				S_LERP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(NCoord + 1)) st_q <= S_OUT;
				end
				S_OUT: begin
					st_q <= S_IDLE;
					ovalid_q <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				// capture only on accept; hold a waiting result
				if (acc) begin
					c_q <= in_c;
					t_q <= in_req > in_now ? in_now : in_req;
					fstamp_q <= $signed({2'b0, in_now});
					status_q <= ST_ACK;
					res_q <= '0;
					frac_q <= '0;
				end
			end
			S_FILL: fstamp_q <= fstamp_q - $signed({{(TimeW+2-PeriodW){1'b0}}, period_q});
			S_WALK: begin
				if (cnt_q != '0) begin
					if (rstamp <= t_q) begin
						i_q <= idx_t'(top_q - cnt_q[IdxW-1:0] + 1'b1);
						j_q <= idx_t'(top_q - cnt_q[IdxW-1:0] + 2'd2);
						status_q <= cnt_q == CntW'(1) ? ST_NOADJ : ST_INTERP;
					end else if (cnt_q == CntW'(Depth)) begin
						i_q <= idx_t'(top_q + 1'b1);
						j_q <= idx_t'(top_q + 1'b1);
						status_q <= ST_OLDEST;
					end
				end
			end
			S_RDI: ;
			S_RDJ: begin
				if (cnt_q == CntW'(0)) begin
					ti_q <= rstamp;
					ci_q <= rcoord;
				end else if (cnt_q == CntW'(1)) begin
					tj_q <= rstamp;
					cj_q <= rcoord;
					if (status_q == ST_NOADJ) res_q <= c_q;
					else if (status_q == ST_OLDEST) res_q <= rcoord;
				end
			end
			S_DIV: if (div_done) frac_q <= quo;
			S_LERP: begin
				if (cnt_q >= CntW'(2)) res_q[cnt_q[3:0] - 4'd2] <= lres;
			end
			default: ;
		endcase
	end
endmodule

// ===== verif/tb_timed_position_history_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_position_history_lookup
// Drives stores, fills and queries into the marker ring with random stalls on
// both streams, predicts every result in a scoreboard and compares each field.
// ----------------------------------------------------------------------------
module tb_timed_position_history_lookup;
	import tphl_pkg::*;

	typedef struct {
		logic [1:0] status;
		logic signed [CoordW-1:0] c [NCoord];
	} outcome_t;

	class history_scoreboard;
		logic [IdxW-1:0] top;
		logic [TimeW-1:0] stamps [Depth];
		logic signed [CoordW-1:0] coords [Depth][NCoord];
		logic [PeriodW-1:0] period;
		outcome_t pending [$];
		int errors;
		string fnames [NCoord] = '{"pos_x", "pos_y", "pos_z", "lo_x", "lo_y", "lo_z",
			"hi_x", "hi_y", "hi_z"};

		function new();
			top = IdxW'(Depth - 1);
			period = PERIOD_RESET;
			errors = 0;
			for (int e = 0; e < Depth; e++) begin
				stamps[e] = '0;
				for (int k = 0; k < NCoord; k++) coords[e][k] = '0;
			end
		endfunction

		function automatic logic signed [CoordW-1:0] blend(
				logic signed [CoordW-1:0] a, logic signed [CoordW-1:0] b,
				logic [16:0] frac);
			longint prod, delta, v;
			prod = (longint'(b) - longint'(a)) * longint'(frac);
			delta = prod >>> 16; // arithmetic shift floors
			v = longint'(a) + delta;
			if (v > 8388607) v = 8388607;
			if (v < -8388608) v = -8388608;
			return CoordW'(v);
		endfunction

		function void note_item(logic [295:0] d);
			logic [1:0] op;
			logic [TimeW-1:0] req, now, t, ti, tj;
			logic signed [CoordW-1:0] c [NCoord];
			outcome_t o;
			int i, j, tp;
			longint st;
			longint unsigned q;
			logic [16:0] frac;
			op = d[1:0];
			req = d[32:2];
			now = d[63:33];
			for (int k = 0; k < NCoord; k++) begin
				c[k] = d[64 + CoordW*k +: CoordW];
				o.c[k] = '0;
			end
			o.status = ST_ACK;
			if (op == OP_STORE) begin
				top = top + 1'b1;
				stamps[top] = now;
				for (int k = 0; k < NCoord; k++) coords[top][k] = c[k];
			end else if (op == OP_FILL) begin
				top = IdxW'(Depth - 1);
				st = now;
				for (int e = Depth - 1; e >= 0; e--) begin
					stamps[e] = (st < 0) ? '0 : TimeW'(st);
					for (int k = 0; k < NCoord; k++) coords[e][k] = c[k];
					st -= period;
				end
			end else if (op == OP_QUERY) begin
				t = (req > now) ? now : req;
				tp = top;
				i = tp;
				j = tp;
				do begin
					if (stamps[i] <= t) break;
					j = i;
					i = (i == 0) ? Depth - 1 : i - 1;
				end while (i != tp);
				if (i == j) begin
					o.status = ST_NOADJ;
					for (int k = 0; k < NCoord; k++) o.c[k] = c[k];
				end else if (i == tp) begin
					o.status = ST_OLDEST;
					for (int k = 0; k < NCoord; k++) o.c[k] = coords[j][k];
				end else begin
					o.status = ST_INTERP;
					ti = stamps[i];
					tj = stamps[j];
					frac = 0;
					if (tj > ti && t >= ti) begin
						q = (longint'(t - ti) << 16) / longint'(tj - ti);
						frac = (q > 65535) ? 17'd65535 : 17'(q);
					end
					for (int k = 0; k < NCoord; k++)
						o.c[k] = blend(coords[i][k], coords[j][k], frac);
				end
			end
			pending.push_back(o);
		endfunction

		function void check_result(logic [223:0] d);
			outcome_t o;
			logic signed [CoordW-1:0] got;
			if (pending.size() == 0) begin
				$error("result with no pending expectation");
				errors++;
				return;
			end
			o = pending.pop_front();
			if (d[1:0] !== o.status) begin
				$error("status expected %0d actual %0d", o.status, d[1:0]);
				errors++;
			end
			for (int k = 0; k < NCoord; k++) begin
				got = d[2 + CoordW*k +: CoordW];
				if (got !== o.c[k]) begin
					$error("%s expected %0d actual %0d", fnames[k], o.c[k], got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [295:0] s_axis_tdata;
	logic [223:0] m_axis_tdata;
	logic cfg_valid, cfg_ready;
	logic [PeriodW-1:0] cfg_data;

	history_scoreboard board;
	int idle_cycles;
	bit calm;      // no idling in the last part
	bit hold_sink; // long receiver hold-off
	logic [TimeW-1:0] clock_ms;

	timed_position_history_lookup dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		board = new();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_data = '0;
		calm = 0;
		hold_sink = 0;
		clock_ms = 1000;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) board.note_item(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 4000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				hold_sink = 0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 0;
				n = $urandom_range(1, 14);
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				n = $urandom_range(1, 20);
				repeat (n) @(posedge clk);
			end
		end
	end

	function automatic logic [23:0] rand_coord(int mode);
		case (mode)
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'(signed'($urandom_range(0, 4000)) - 2000);
			default: return 24'($urandom);
		endcase
	endfunction

	// tvalid stays up after an accept; the next item or a pause replaces it
	task automatic send_item(logic [1:0] op, logic [TimeW-1:0] req,
			logic [TimeW-1:0] now, int mode);
		logic [295:0] d;
		int n;
		d = '0;
		d[1:0] = op;
		d[32:2] = req;
		d[63:33] = now;
		for (int k = 0; k < NCoord; k++)
			d[64 + CoordW*k +: CoordW] = rand_coord(mode < 0 ? $urandom_range(0, 5) : mode);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 0;
			n = $urandom_range(1, 14);
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_period(logic [PeriodW-1:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		board.period = v;
	endtask

	task automatic random_item();
		int pick;
		logic [TimeW-1:0] now, req;
		pick = $urandom_range(0, 19);
		clock_ms = clock_ms + TimeW'($urandom_range(0, 60));
		now = clock_ms;
		case ($urandom_range(0, 9))
			0: req = TimeW'($urandom);
			1: req = now - TimeW'($urandom_range(0, 20000));
			2: req = 0;
			default: req = now - TimeW'($urandom_range(0, 900));
		endcase
		if (pick == 0) send_item(OP_FILL, TimeW'($urandom), now, -1);
		else if (pick == 1) send_item(OP_UNUSED, TimeW'($urandom), TimeW'($urandom), -1);
		else if (pick == 2) send_item(OP_STORE, req, TimeW'($urandom), -1);
		else if (pick < 10) send_item(OP_STORE, req, now, -1);
		else send_item(OP_QUERY, req, now, -1);
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		// directed: empty ring, extremes, every opcode
		send_item(OP_QUERY, 0, 0, 2);
		send_item(OP_QUERY, 31'h7FFFFFFF, 31'h7FFFFFFF, 0);
		send_item(OP_STORE, 0, 31'h7FFFFFFF, 0);
		send_item(OP_STORE, 0, 100, 1);
		send_item(OP_STORE, 0, 100, 0);
		send_item(OP_QUERY, 31'h7FFFFFFF, 50, 3);
		send_item(OP_QUERY, 100, 200, 3);
		send_item(OP_UNUSED, 31'h7FFFFFFF, 31'h7FFFFFFF, 0);
		send_item(OP_FILL, 0, 30, 0);
		send_item(OP_QUERY, 0, 30, 3);
		send_item(OP_QUERY, 29, 40, 3);
		send_item(OP_STORE, 0, 1030, 1);
		send_item(OP_QUERY, 1010, 2000, 2);
		send_item(OP_QUERY, 10, 2000, 2);
		write_period(10'd1000);
		send_item(OP_FILL, 0, 31'h7FFFFFFF, 1);
		send_item(OP_QUERY, 31'h7FFFF000, 31'h7FFFFFFF, 4);
		write_period(10'd0);
		send_item(OP_FILL, 0, 5000, 0);
		send_item(OP_QUERY, 4000, 5000, 4);
		send_item(OP_QUERY, 5000, 6000, 4);
		write_period(10'd1);
		send_item(OP_FILL, 0, 5000, 4);
		send_item(OP_STORE, 0, 5002, 1);
		send_item(OP_QUERY, 5001, 6000, 4);
		// receiver holds off while the sender keeps offering
		hold_sink = 1;
		for (int n = 0; n < 10; n++) random_item();
		drain();
		for (int phase = 0; phase < 4; phase++) begin
			write_period(phase == 0 ? 10'd50 : PeriodW'($urandom_range(0, 1000)));
			for (int n = 0; n < 250; n++) random_item();
		end
		calm = 1;
		for (int n = 0; n < 130; n++) random_item();
		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
